FILE: hw/rtl/lsir_pkg.sv
// Shared types, constants and the angle threshold table for the level to sector indicator.
// No dependencies.
package lsir_pkg;

    localparam int SAMPLE_PORT_W = 12;
    localparam int ANGLE_W       = 6;
    localparam int DEG_W         = 9;
    localparam int SHADE_W       = 2;
    localparam int THR_W         = 18;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [ANGLE_W-1:0] ANGLE_STEPS   = 6'd45;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 6'd45;
    localparam logic [DEG_W-1:0]   LEFT_BASE     = 9'd315;
    localparam logic [DEG_W-1:0]   RIGHT_BASE    = 9'd405;

    localparam logic [SHADE_W-1:0] SHADE_MEDIUM = 2'd0;
    localparam logic [SHADE_W-1:0] SHADE_BRIGHT = 2'd1;
    localparam logic [SHADE_W-1:0] SHADE_DARK   = 2'd2;

    // register index of max_half_angle
    localparam logic REG_MAX_HALF_ANGLE = 1'b0;

    // one target angle moving from the front to the back
    typedef struct packed {
        logic               valid;
        logic [ANGLE_W-1:0] angle;
    } angle_req_t;

    // smallest Q.8 level at which the mapping reaches a half angle of idx+1 degrees
    function automatic logic [THR_W-1:0] level_threshold(input logic [ANGLE_W-1:0] idx);
        logic [THR_W-1:0] t;
        case (idx)
            6'd0:  t = 18'd147;
            6'd1:  t = 18'd375;
            6'd2:  t = 18'd724;
            6'd3:  t = 18'd1253;
            6'd4:  t = 18'd2036;
            6'd5:  t = 18'd3160;
            6'd6:  t = 18'd4717;
            6'd7:  t = 18'd6785;
            6'd8:  t = 18'd9414;
            6'd9:  t = 18'd12615;
            6'd10: t = 18'd16369;
            6'd11: t = 18'd20630;
            6'd12: t = 18'd25344;
            6'd13: t = 18'd30454;
            6'd14: t = 18'd35905;
            6'd15: t = 18'd41648;
            6'd16: t = 18'd47643;
            6'd17: t = 18'd53855;
            6'd18: t = 18'd60253;
            6'd19: t = 18'd66813;
            6'd20: t = 18'd73514;
            6'd21: t = 18'd80338;
            6'd22: t = 18'd87272;
            6'd23: t = 18'd94303;
            6'd24: t = 18'd101420;
            6'd25: t = 18'd108614;
            6'd26: t = 18'd115877;
            6'd27: t = 18'd123203;
            6'd28: t = 18'd130585;
            6'd29: t = 18'd138020;
            6'd30: t = 18'd145501;
            6'd31: t = 18'd153026;
            6'd32: t = 18'd160590;
            6'd33: t = 18'd168191;
            6'd34: t = 18'd175826;
            6'd35: t = 18'd183492;
            6'd36: t = 18'd191187;
            6'd37: t = 18'd198910;
            6'd38: t = 18'd206658;
            6'd39: t = 18'd214429;
            6'd40: t = 18'd222223;
            6'd41: t = 18'd230038;
            6'd42: t = 18'd237872;
            6'd43: t = 18'd245725;
            6'd44: t = 18'd253595;
            default: t = {THR_W{1'b1}};
        endcase
        return t;
    endfunction

endpackage

FILE: hw/rtl/lsir_front.sv
// Front end: accepts samples, runs the low-pass filter (divide by ten through a reciprocal
// multiply) and maps the level to a clamped half angle by binary search. Depends on lsir_pkg.
module lsir_front
    import lsir_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_PORT_W-1:0] level_sample,
    input  logic [ANGLE_W-1:0]       max_half_angle,
    output angle_req_t               push,
    input  logic                     push_ready
);

    localparam int LVL_W   = SAMPLE_BITS + FRACTION_BITS;
    localparam int NUM_W   = LVL_W + 4;
    localparam int Q8_W    = LVL_W + 8;
    localparam int DIV_SH  = NUM_W + 4;
    localparam int RECIP_W = DIV_SH - 3;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SH) + 64'd9) / 64'd10);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIV  = 4'b0010,
        F_MAP  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t             state_reg, state_next;
    logic [LVL_W-1:0]         level_reg, level_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [2:0]               bit_reg, bit_next;
    logic [ANGLE_W-1:0]       cnt_reg, cnt_next;
    logic [ANGLE_W-1:0]       target_reg, target_next;

    logic [SAMPLE_BITS-1:0]   sample_x;
    logic [PROD_W-1:0]        div_prod;
    logic [Q8_W-1:0]          level_q8;
    logic [ANGLE_W-1:0]       cand;
    logic                     cand_hit;

    always_comb
    begin
        for (int i = 0; i < SAMPLE_BITS; i++)
        begin
            if (i < SAMPLE_PORT_W)
                sample_x[i] = level_sample[i];
            else
                sample_x[i] = 1'b0;
        end
    end

    assign in_ready   = (state_reg == F_IDLE);
    assign push.valid = (state_reg == F_PUSH);
    assign push.angle = target_reg;

    // divide by ten: multiply by the rounded-up reciprocal and shift; the rounding
    // error stays below one quotient step for every sum the filter can form
    assign div_prod = PROD_W'(num_reg) * PROD_W'(DIV_RECIP);

    assign level_q8 = {level_reg, 8'b0} >> FRACTION_BITS;
    assign cand     = cnt_reg | (ANGLE_W'(1) << bit_reg);
    assign cand_hit = (cand <= ANGLE_STEPS) &&
                      (level_q8 >= Q8_W'(level_threshold(cand - ANGLE_W'(1))));

    always_comb
    begin
        state_next  = state_reg;
        level_next  = level_reg;
        num_next    = num_reg;
        bit_next    = bit_reg;
        cnt_next    = cnt_reg;
        target_next = target_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    // 9*f + (x << F)
                    num_next  = (NUM_W'(level_reg) << 3) + NUM_W'(level_reg) +
                                (NUM_W'(sample_x) << FRACTION_BITS);
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                level_next = div_prod[DIV_SH +: LVL_W];
                bit_next   = 3'd5;
                cnt_next   = '0;
                state_next = F_MAP;
            end
            F_MAP:
            begin
                if (cand_hit)
                    cnt_next = cand;
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    target_next = (cnt_next > max_half_angle) ? max_half_angle : cnt_next;
                    state_next  = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        bit_reg    <= bit_next;
        cnt_reg    <= cnt_next;
        target_reg <= target_next;
    end

endmodule

FILE: hw/rtl/lsir_queue.sv
// Two-entry queue of target angles between the front and back ends.
// Depends on lsir_pkg.
module lsir_queue
    import lsir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  angle_req_t push,
    output logic       push_ready,
    output angle_req_t pop,
    input  logic       pop_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [ANGLE_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               do_push, do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop.valid  = (fill_reg != '0);
    assign pop.angle  = mem[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + FILL_W'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.angle;
    end

endmodule

FILE: hw/rtl/lsir_back.sv
// Back end: walks the shown angle toward each queued target and emits one line pair per
// cycle while the receiver takes them, through an output register. Depends on lsir_pkg.
module lsir_back
    import lsir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  angle_req_t         pop,
    output logic               pop_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DEG_W-1:0]   left_angle,
    output logic [DEG_W-1:0]   right_angle,
    output logic [SHADE_W-1:0] shade,
    output logic               last_of_run
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } back_state_t;

    back_state_t        state_reg;
    logic [ANGLE_W-1:0] shown_reg;
    logic [ANGLE_W-1:0] cur_reg;
    logic [ANGLE_W-1:0] tgt_reg;
    logic               up_reg;
    logic               out_valid_reg;
    logic [DEG_W-1:0]   left_reg, right_reg;
    logic [SHADE_W-1:0] shade_reg;
    logic               last_reg;

    logic               slot_free;
    logic               emit;
    logic               at_end;

    assign pop_ready = (state_reg == B_IDLE);
    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = (state_reg == B_RUN) && slot_free;
    assign at_end    = (cur_reg == tgt_reg);

    assign out_valid   = out_valid_reg;
    assign left_angle  = left_reg;
    assign right_angle = right_reg;
    assign shade       = shade_reg;
    assign last_of_run = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            shown_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (pop.valid && pop.angle != shown_reg)
                        state_reg <= B_RUN;
                end
                B_RUN:
                begin
                    if (emit && at_end)
                    begin
                        state_reg <= B_IDLE;
                        shown_reg <= tgt_reg;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE)
        begin
            cur_reg <= shown_reg;
            tgt_reg <= pop.angle;
            up_reg  <= (pop.angle > shown_reg);
        end
        else if (emit && !at_end)
        begin
            cur_reg <= up_reg ? cur_reg + ANGLE_W'(1) : cur_reg - ANGLE_W'(1);
        end
        if (emit)
        begin
            left_reg  <= LEFT_BASE + DEG_W'(cur_reg);
            right_reg <= RIGHT_BASE - DEG_W'(cur_reg);
            last_reg  <= at_end;
            if (at_end)
                shade_reg <= SHADE_BRIGHT;
            else if (up_reg)
                shade_reg <= SHADE_MEDIUM;
            else
                shade_reg <= SHADE_DARK;
        end
    end

endmodule

FILE: hw/rtl/level_to_sector_indicator_runs_top.sv
// Top level of the level to sector indicator: config register, front end, queue, back end.
// Depends on lsir_pkg, lsir_front, lsir_queue, lsir_back.
//
// Usage:
//   Input channel (in_valid/in_ready, level_sample) takes one level sample per request.
//   Output channel (out_valid/out_ready) returns line pairs: left_angle, right_angle,
//   shade and last_of_run. A changed angle gives |new - old| + 1 pairs, the bright
//   pair at the new angle last; an unchanged angle gives none.
//   Front end: a sample is accepted, divided by ten (reciprocal multiply), mapped by a
//   binary search of the threshold table and queued as a target. The front is busy
//   while working on a sample, so it takes no new sample until the last is queued.
//   Back end: it picks up a target while idle, then gives one pair per cycle while
//   the receiver takes them; a queued target passes the queue, the back end's idle
//   state and the output register before its first pair is on the output.
//   A two-entry queue lets the front run ahead while the back is stalled; when the
//   receiver holds out_ready low the output register holds and both ends back up.
//   Reset clears the filter level and shown angle to zero and max_half_angle to 45.
//   APB: max_half_angle at address 0; write only while the block is idle.
module level_to_sector_indicator_runs_top
    import lsir_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_PORT_W-1:0] level_sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [DEG_W-1:0]         left_angle,
    output logic [DEG_W-1:0]         right_angle,
    output logic [SHADE_W-1:0]       shade,
    output logic                     last_of_run
);

    logic [ANGLE_W-1:0] max_half_angle_reg;
    angle_req_t         push;
    angle_req_t         pop;
    logic               push_ready;
    logic               pop_ready;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_MAX_HALF_ANGLE);
    assign prdata  = reg_sel ? 32'(max_half_angle_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_half_angle_reg <= MAX_ANGLE_RST;
        else if (psel && penable && pwrite && pready && reg_sel)
            max_half_angle_reg <= pwdata[ANGLE_W-1:0];
    end

    lsir_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .level_sample   (level_sample),
        .max_half_angle (max_half_angle_reg),
        .push           (push),
        .push_ready     (push_ready)
    );

    lsir_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    lsir_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop         (pop),
        .pop_ready   (pop_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_angle  (left_angle),
        .right_angle (right_angle),
        .shade       (shade),
        .last_of_run (last_of_run)
    );

    // the pair is always mirrored about 360 degrees
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((10'(left_angle) + 10'(right_angle)) == 10'd720))
        else $error("sector pair not mirrored");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_run) |-> (shade == SHADE_BRIGHT))
        else $error("run not closed by bright pair");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && shade == SHADE_BRIGHT) |-> last_of_run)
        else $error("bright pair without end of run");

    // a queued target never exceeds the clamp or the table range
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (push.angle <= max_half_angle_reg && push.angle <= ANGLE_STEPS))
        else $error("target angle out of range");

endmodule

FILE: tb/sv/lsir_run_checker.sv
`timescale 1ns / 100ps
// Watches the register port and both channels of the level to sector indicator, predicts
// the line-pair runs from each accepted level sample and compares them with the output.
// Depends on lsir_pkg for widths, shade codes and the other shared constants.
module lsir_run_checker
    import lsir_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [SAMPLE_PORT_W-1:0] level_sample,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [DEG_W-1:0]         left_angle,
    input  logic [DEG_W-1:0]         right_angle,
    input  logic [SHADE_W-1:0]       shade,
    input  logic                     last_of_run,
    output int                       fail_count,
    output int                       pairs_outstanding
);

    localparam int STEP_W = 18;
    localparam int STEPS  = 45;

    // Q.8 level at which the half angle reaches k+1, entry k at [k*STEP_W +: STEP_W]
    localparam logic [STEPS*STEP_W-1:0] ANGLE_STEP_LEVELS = {
        18'd253595, 18'd245725, 18'd237872, 18'd230038, 18'd222223, 18'd214429,
        18'd206658, 18'd198910, 18'd191187, 18'd183492, 18'd175826, 18'd168191,
        18'd160590, 18'd153026, 18'd145501, 18'd138020, 18'd130585, 18'd123203,
        18'd115877, 18'd108614, 18'd101420, 18'd94303,  18'd87272,  18'd80338,
        18'd73514,  18'd66813,  18'd60253,  18'd53855,  18'd47643,  18'd41648,
        18'd35905,  18'd30454,  18'd25344,  18'd20630,  18'd16369,  18'd12615,
        18'd9414,   18'd6785,   18'd4717,   18'd3160,   18'd2036,   18'd1253,
        18'd724,    18'd375,    18'd147
    };

    typedef struct packed {
        logic [DEG_W-1:0]   left_deg;
        logic [DEG_W-1:0]   right_deg;
        logic [SHADE_W-1:0] shade;
        logic               last;
    } line_pair_t;

    line_pair_t         pairs_due [$];
    logic [19:0]        filtered_level;
    logic [ANGLE_W-1:0] shown_angle;
    logic [ANGLE_W-1:0] angle_clamp;
    int                 failures;

    function automatic line_pair_t make_pair(input logic [ANGLE_W-1:0] a,
                                             input logic [SHADE_W-1:0] s,
                                             input logic l);
        line_pair_t p;
        p.left_deg  = LEFT_BASE + DEG_W'(a);
        p.right_deg = RIGHT_BASE - DEG_W'(a);
        p.shade     = s;
        p.last      = l;
        return p;
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_for_level(input logic [19:0] lvl);
        logic [31:0]        q8;
        logic [ANGLE_W-1:0] n;
        q8 = ({12'd0, lvl} << 8) >> FRACTION_BITS;
        n = '0;
        for (int k = 0; k < STEPS; k++)
            if (q8 >= {14'd0, ANGLE_STEP_LEVELS[k*STEP_W +: STEP_W]})
                n = ANGLE_W'(k + 1);
        return n;
    endfunction

    task automatic predict_run(input logic [SAMPLE_PORT_W-1:0] x);
        logic [31:0]        mixed;
        logic [ANGLE_W-1:0] target;
        logic [ANGLE_W-1:0] a;
        mixed = 32'd9 * {12'd0, filtered_level} + ({20'd0, x} << FRACTION_BITS);
        filtered_level = 20'(mixed / 32'd10);
        target = angle_for_level(filtered_level);
        if (target > angle_clamp)
            target = angle_clamp;
        if (target != shown_angle) begin
            if (target > shown_angle) begin
                for (a = shown_angle; a < target; a++)
                    pairs_due.push_back(make_pair(a, SHADE_MEDIUM, 1'b0));
            end
            else begin
                for (a = shown_angle; a > target; a--)
                    pairs_due.push_back(make_pair(a, SHADE_DARK, 1'b0));
            end
            pairs_due.push_back(make_pair(target, SHADE_BRIGHT, 1'b1));
        end
        shown_angle = target;
    endtask

    always @(posedge clk or negedge rst_n) begin
        line_pair_t seen;
        line_pair_t want;
        if (!rst_n) begin
            filtered_level = '0;
            shown_angle    = '0;
            angle_clamp    = MAX_ANGLE_RST;
            failures       = 0;
            pairs_due.delete();
        end
        else begin
            if (psel && penable && pwrite && pready
                && paddr[2] == REG_MAX_HALF_ANGLE && paddr[1:0] == 2'b00)
                angle_clamp = pwdata[ANGLE_W-1:0];

            if (out_valid && out_ready) begin
                seen = '{left_angle, right_angle, shade, last_of_run};
                if (pairs_due.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected line pair: left %0d right %0d shade %0d last %0d",
                                 seen.left_deg, seen.right_deg, seen.shade, seen.last);
                end
                else begin
                    want = pairs_due.pop_front();
                    if (seen.left_deg != want.left_deg || seen.right_deg != want.right_deg
                        || seen.shade != want.shade || seen.last != want.last) begin
                        failures++;
                        if (failures <= 10)
                            $display({"line pair mismatch: expected left %0d right %0d ",
                                      "shade %0d last %0d, got left %0d right %0d ",
                                      "shade %0d last %0d"},
                                     want.left_deg, want.right_deg, want.shade, want.last,
                                     seen.left_deg, seen.right_deg, seen.shade, seen.last);
                    end
                end
            end

            if (in_valid && in_ready)
                predict_run(level_sample);
        end
        fail_count        <= failures;
        pairs_outstanding <= pairs_due.size();
    end

endmodule

FILE: tb/sv/level_to_sector_indicator_runs_top_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for level_to_sector_indicator_runs_top: drives level samples and
// clamp writes, stalls the output at random. Depends on lsir_pkg and lsir_run_checker.
module level_to_sector_indicator_runs_top_tb;
    import lsir_pkg::*;

    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          IDLE_PCT      = 36;
    localparam logic [2:0]  CLAMP_ADDR    = {REG_MAX_HALF_ANGLE, 2'b00};
    localparam logic [2:0]  SPARE_ADDR    = 3'd4;
    localparam logic [11:0] FULL_SCALE    = 12'd4095;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [2:0]               paddr        = '0;
    logic [31:0]              pwdata       = '0;
    logic                     in_valid     = 1'b0;
    logic [SAMPLE_PORT_W-1:0] level_sample = '0;
    logic                     out_ready    = 1'b0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     in_ready;
    logic                     out_valid;
    logic [DEG_W-1:0]         left_angle;
    logic [DEG_W-1:0]         right_angle;
    logic [SHADE_W-1:0]       shade;
    logic                     last_of_run;

    int          fail_count;
    int          pairs_pending;
    int unsigned cycle_count = 0;
    bit          in_gaps     = 1'b1;
    bit          out_stalls  = 1'b1;

    always #1 clk = ~clk;

    level_to_sector_indicator_runs_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .level_sample(level_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_angle  (left_angle),
        .right_angle (right_angle),
        .shade       (shade),
        .last_of_run (last_of_run)
    );

    lsir_run_checker run_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .level_sample     (level_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_angle       (left_angle),
        .right_angle      (right_angle),
        .shade            (shade),
        .last_of_run      (last_of_run),
        .fail_count       (fail_count),
        .pairs_outstanding(pairs_pending)
    );

    always @(posedge clk)
        out_ready <= !out_stalls || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_level(input logic [SAMPLE_PORT_W-1:0] value);
        while (in_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        level_sample <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    // first edge lets the checker see the last request before pending is read
    task automatic wait_drained;
        @(posedge clk);
        while (pairs_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // bursts around a held level so the filter settles at many angles, with some noise
    task automatic play_levels(input int n_items);
        int                       remaining;
        int                       burst_len;
        logic [SAMPLE_PORT_W-1:0] base;
        remaining = n_items;
        while (remaining > 0) begin
            base      = SAMPLE_PORT_W'($urandom_range(0, 4095) >> $urandom_range(0, 11));
            burst_len = $urandom_range(1, 10);
            for (int i = 0; i < burst_len && remaining > 0; i++) begin
                if ($urandom_range(0, 9) < 2)
                    send_level(SAMPLE_PORT_W'($urandom));
                else
                    send_level(base ^ SAMPLE_PORT_W'($urandom_range(0, 3)));
                remaining--;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset clamp: no change, big rises, saturation, then falls
        send_level(12'd0);
        repeat (4) send_level(FULL_SCALE);
        send_level(12'hAAA);
        send_level(12'h555);
        repeat (3) send_level(12'd0);

        // clamp at zero while the filter climbs, then release for a full 0..45 run
        write_reg(CLAMP_ADDR, 32'd0);
        repeat (3) send_level(FULL_SCALE);
        write_reg(CLAMP_ADDR, 32'd45);
        send_level(FULL_SCALE);
        write_reg(CLAMP_ADDR, 32'd0);
        send_level(FULL_SCALE);
        write_reg(CLAMP_ADDR, 32'd63);
        send_level(FULL_SCALE);
        // lowered clamp below the shown angle
        write_reg(CLAMP_ADDR, 32'd10);
        send_level(FULL_SCALE);
        write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
        send_level(FULL_SCALE);
        // only the low bits of the data count
        write_reg(CLAMP_ADDR, {26'h3FF_FFFF, 6'd1});
        send_level(12'd0);

        write_reg(CLAMP_ADDR, 32'd45);
        play_levels(70);
        write_reg(CLAMP_ADDR, 32'd63);
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
        play_levels(50);
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
        write_reg(CLAMP_ADDR, 32'($urandom_range(1, 44)));
        play_levels(50);
        write_reg(CLAMP_ADDR, 32'd0);
        play_levels(20);
        write_reg(CLAMP_ADDR, {26'($urandom), 6'd45});
        play_levels(70);
        write_reg(SPARE_ADDR, $urandom);
        play_levels(50);

        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pairs_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
